@@ rtl/t2e_pkg.sv @@
// Shared types and constants of the tunnel to Ethernet encapsulator.
package t2e_pkg;

	localparam int HDR_LEN = 14;
	localparam int Q_DEPTH = 4;
	localparam int Q_AW = 2;

	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
	localparam logic [3:0] VER_IPV4 = 4'd4;
	localparam logic [3:0] VER_IPV6 = 4'd6;
	localparam logic [2:0] FAMILY_BYTES = 3'd4;
	localparam logic [2:0] IDX_BODY = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_NOT_IP = 2'd2;
	localparam logic [1:0] ST_TOO_LONG = 2'd3;

	localparam logic [2:0] REG_DST_MAC = 3'd0;
	localparam logic [2:0] REG_SOURCE_MAC = 3'd1;
	localparam logic [2:0] REG_MAX_FRAME_LEN = 3'd2;
	localparam logic [2:0] REG_FAMILY_IPV4 = 3'd3;
	localparam logic [2:0] REG_FAMILY_IPV6 = 3'd4;

	typedef enum logic [1:0] {
		CMD_DATA = 2'd0,
		CMD_HDR = 2'd1,
		CMD_ERR = 2'd2
	} cmd_kind_t;

	// One work item for the back part: a frame byte, a header plus byte, or an error.
	typedef struct packed {
		cmd_kind_t kind;
		logic [7:0] data;
		logic last;
		logic is_v6;
		logic [1:0] status;
	} cmd_t;

	typedef struct packed {
		logic [47:0] dst_mac;
		logic [47:0] source_mac;
		logic [15:0] max_frame_len;
		logic [31:0] family_ipv4_code;
		logic [31:0] family_ipv6_code;
	} cfg_t;

endpackage

@@ rtl/t2e_front.sv @@
// Front part: collects the family word, classifies the packet and issues commands.
module t2e_front (
	input logic clk,
	input logic arst_n,
	input t2e_pkg::cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] in_byte,
	input logic in_last,
	output logic push,
	output t2e_pkg::cmd_t push_cmd,
	input logic q_full
);
	import t2e_pkg::*;

	logic [2:0] idx_q;
	logic [31:0] fam_q;
	logic disc_q;
	logic take;
	logic [3:0] ver;
	logic is_v4;
	logic is_v6;

	assign in_ready = !q_full;
	assign take = in_valid && in_ready;
	assign ver = in_byte[7:4];

	always_comb begin
		is_v4 = 1'b0;
		is_v6 = 1'b0;
		if (fam_q == cfg.family_ipv4_code) begin
			is_v4 = 1'b1;
		end else if (fam_q == cfg.family_ipv6_code) begin
			is_v6 = 1'b1;
		end else if (ver == VER_IPV4) begin
			is_v4 = 1'b1;
		end else if (ver == VER_IPV6) begin
			is_v6 = 1'b1;
		end
	end

	always_comb begin
		push = 1'b0;
		push_cmd.kind = CMD_DATA;
		push_cmd.data = in_byte;
		push_cmd.last = in_last;
		push_cmd.is_v6 = is_v6;
		push_cmd.status = ST_OK;
		if (take && !disc_q) begin
			if (idx_q < FAMILY_BYTES) begin
				if (in_last) begin
					push = 1'b1;
					push_cmd.kind = CMD_ERR;
					push_cmd.status = ST_SHORT;
				end
			end else if (idx_q == FAMILY_BYTES) begin
				push = 1'b1;
				if (is_v4 || is_v6) begin
					push_cmd.kind = CMD_HDR;
				end else begin
					push_cmd.kind = CMD_ERR;
					push_cmd.status = ST_NOT_IP;
				end
			end else begin
				push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			fam_q <= '0;
			disc_q <= 1'b0;
		end else if (take) begin
			if (disc_q) begin
				if (in_last) begin
					disc_q <= 1'b0;
					idx_q <= '0;
					fam_q <= '0;
				end
			end else if (in_last) begin
				idx_q <= '0;
				fam_q <= '0;
			end else if (idx_q < FAMILY_BYTES) begin
				fam_q <= {fam_q[23:0], in_byte};
				idx_q <= idx_q + 3'd1;
			end else if (idx_q == FAMILY_BYTES) begin
				if (is_v4 || is_v6) begin
					idx_q <= IDX_BODY;
				end else begin
					// unknown type: drop the rest of the packet
					disc_q <= 1'b1;
					idx_q <= '0;
					fam_q <= '0;
				end
			end
		end
	end

endmodule

@@ rtl/t2e_queue.sv @@
// Short command queue between the front and back parts.
module t2e_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input t2e_pkg::cmd_t push_cmd,
	output logic full,
	input logic pop,
	output logic valid,
	output t2e_pkg::cmd_t head
);
	import t2e_pkg::*;

	cmd_t mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_AW:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign valid = (cnt_q != '0);
	assign head = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + Q_AW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + Q_AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (Q_AW+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (Q_AW+1)'(1);
			end
		end
	end

endmodule

@@ rtl/t2e_back.sv @@
// Back part: expands commands into frame words, enforces the frame limit, holds output.
module t2e_back #(
	parameter int LENGTH_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input t2e_pkg::cfg_t cfg,
	input logic cmd_valid,
	input t2e_pkg::cmd_t cmd,
	output logic cmd_pop,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] out_byte,
	output logic out_last,
	output logic [1:0] status
);
	import t2e_pkg::*;

	localparam int CW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

	logic [LENGTH_BITS-1:0] olen_q;
	logic [3:0] cnt_q;
	logic drop_q;
	logic out_v_q;
	logic [7:0] byte_q;
	logic last_q;
	logic [1:0] st_q;

	logic step;
	logic in_hdr;
	logic at_limit;
	logic emit;
	logic [7:0] hdr_b [HDR_LEN];
	logic [7:0] cur_byte;
	logic [15:0] etype;
	logic [CW-1:0] mfl_w;
	logic [CW-1:0] mask_w;
	logic [CW-1:0] limit_w;

	assign mfl_w = CW'(cfg.max_frame_len);
	assign mask_w = CW'({LENGTH_BITS{1'b1}});
	assign limit_w = (mfl_w < mask_w) ? mfl_w : mask_w;
	assign at_limit = (CW'(olen_q) >= limit_w);

	assign etype = cmd.is_v6 ? ETYPE_IPV6 : ETYPE_IPV4;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			hdr_b[i] = cfg.dst_mac[8*(5-i) +: 8];
			hdr_b[6+i] = cfg.source_mac[8*(5-i) +: 8];
		end
		hdr_b[12] = etype[15:8];
		hdr_b[13] = etype[7:0];
	end

	assign in_hdr = (cmd.kind == CMD_HDR) && (cnt_q < 4'(HDR_LEN));
	assign cur_byte = in_hdr ? hdr_b[cnt_q] : cmd.data;

	assign step = cmd_valid && (!out_v_q || out_ready);
	assign emit = step && !drop_q;

	// pop at the end of a command: its last word, an error, the frame limit or while dropping
	always_comb begin
		cmd_pop = 1'b0;
		if (step) begin
			if (drop_q || cmd.kind == CMD_ERR || at_limit || !in_hdr) begin
				cmd_pop = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			olen_q <= '0;
			cnt_q <= '0;
			drop_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			if (step) begin
				if (drop_q) begin
					if (cmd.last) begin
						drop_q <= 1'b0;
					end
				end else if (cmd.kind == CMD_ERR) begin
					olen_q <= '0;
					cnt_q <= '0;
				end else if (at_limit) begin
					olen_q <= '0;
					cnt_q <= '0;
					drop_q <= !cmd.last;
				end else if (in_hdr) begin
					olen_q <= olen_q + LENGTH_BITS'(1);
					cnt_q <= cnt_q + 4'd1;
				end else begin
					cnt_q <= '0;
					olen_q <= cmd.last ? '0 : olen_q + LENGTH_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (cmd.kind == CMD_ERR) begin
				byte_q <= '0;
				last_q <= 1'b1;
				st_q <= cmd.status;
			end else if (at_limit) begin
				byte_q <= '0;
				last_q <= 1'b1;
				st_q <= ST_TOO_LONG;
			end else begin
				byte_q <= cur_byte;
				last_q <= !in_hdr && cmd.last;
				st_q <= ST_OK;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_byte = byte_q;
	assign out_last = last_q;
	assign status = st_q;

endmodule

@@ rtl/tunnel_to_ethernet_encapsulator.sv @@
// Path: an accepted input word that yields a command enters the command queue at its edge
// and moves from there to the output register once that is free. Throughput: one word
// per cycle on each side unless a full queue or m_tready stalls it; an IP packet of N bytes
// leaves as N + 14 words. The back part emits one word per cycle while m_tready allows,
// so the header burst stalls the input once the four-entry command queue is full.
// Reset: arst_n clears packet state, the queue and config registers to their defaults.
module tunnel_to_ethernet_encapsulator #(
	parameter int LENGTH_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [47:0] cfg_wdata,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata, // in_byte [7:0]
	input logic s_tlast,
	output logic m_tvalid,
	input logic m_tready,
	output logic [7:0] m_tdata, // out_byte [7:0]
	output logic m_tlast,
	output logic [1:0] m_tuser // status [1:0]
);
	import t2e_pkg::*;

	cfg_t cfg_q;
	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic q_valid;
	cmd_t q_head;
	logic q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dst_mac <= '0;
			cfg_q.source_mac <= '0;
			cfg_q.max_frame_len <= 16'd1514;
			cfg_q.family_ipv4_code <= 32'd2;
			cfg_q.family_ipv6_code <= 32'd30;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DST_MAC: cfg_q.dst_mac <= cfg_wdata;
				REG_SOURCE_MAC: cfg_q.source_mac <= cfg_wdata;
				REG_MAX_FRAME_LEN: cfg_q.max_frame_len <= cfg_wdata[15:0];
				REG_FAMILY_IPV4: cfg_q.family_ipv4_code <= cfg_wdata[31:0];
				REG_FAMILY_IPV6: cfg_q.family_ipv6_code <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	t2e_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_byte(s_tdata),
		.in_last(s_tlast),
		.push(push),
		.push_cmd(push_cmd),
		.q_full(q_full)
	);

	t2e_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.full(q_full),
		.pop(q_pop),
		.valid(q_valid),
		.head(q_head)
	);

	t2e_back #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.cmd_valid(q_valid),
		.cmd(q_head),
		.cmd_pop(q_pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_byte(m_tdata),
		.out_last(m_tlast),
		.status(m_tuser)
	);

endmodule
